@@ hdl/token_bucket_shaper_top_macros.svh @@
// Assertion macros for the shaper checker.
`ifndef TOKEN_BUCKET_SHAPER_TOP_MACROS_SVH
`define TOKEN_BUCKET_SHAPER_TOP_MACROS_SVH

// Same-cycle implication, off during reset.
`define TBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tbs check failed");

// Next-cycle implication, off during reset.
`define TBS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tbs check failed");

// Next-cycle implication, active through reset.
`define TBS_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("tbs reset check failed");

`endif

@@ hdl/tbs_pkg.sv @@
package tbs_pkg;

  localparam int REQ_W = 2;
  localparam int TOK_W = 16;
  localparam int ID_W  = 32;
  localparam int EV_W  = 3;
  localparam int CNT_W = 7;

  localparam logic [TOK_W-1:0] DEPTH_RST = 16'd10;
  localparam logic [ID_W-1:0]  ID_RST    = 32'd1;

  typedef enum logic [1:0] {
    OP_ARRIVE = 2'd0,
    OP_TICK   = 2'd1,
    OP_PULL   = 2'd2
  } op_t;

  localparam logic [EV_W-1:0] EV_QUEUED   = 3'd0;
  localparam logic [EV_W-1:0] EV_TOO_BIG  = 3'd1;
  localparam logic [EV_W-1:0] EV_Q1_FULL  = 3'd2;
  localparam logic [EV_W-1:0] EV_TOK_ADD  = 3'd3;
  localparam logic [EV_W-1:0] EV_TOK_DROP = 3'd4;
  localparam logic [EV_W-1:0] EV_SERVED   = 3'd5;
  localparam logic [EV_W-1:0] EV_Q2_EMPTY = 3'd6;

  typedef struct packed {
    op_t              op;
    logic [TOK_W-1:0] need;
    logic [ID_W-1:0]  pid;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

@@ hdl/tbs_front.sv @@
module tbs_front import tbs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [REQ_W-1:0] req_type,
  input  logic [TOK_W-1:0] tokens_needed,
  input  q_stat_t          q_stat,
  output logic             busy,
  output logic             push,
  output cmd_t             cmd
);

  logic [ID_W-1:0] next_id_r;
  op_t             op;

  always_comb begin
    case (req_type)
      OP_ARRIVE: op = OP_ARRIVE;
      OP_TICK:   op = OP_TICK;
      default:   op = OP_PULL;
    endcase
  end

  assign busy     = q_stat.full;
  assign push     = start && !q_stat.full;
  assign cmd.op   = op;
  assign cmd.need = tokens_needed;
  assign cmd.pid  = next_id_r;

  // assign ids in arrival order; dropped arrivals use theirs up too
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_id_r <= ID_RST;
    end else if (push && op == OP_ARRIVE) begin
      next_id_r <= next_id_r + 1'b1;
    end
  end

endmodule

@@ hdl/tbs_cmd_fifo.sv @@
module tbs_cmd_fifo import tbs_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    head_cmd,
  output q_stat_t q_stat
);

  cmd_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       do_push;
  logic       do_pop;

  assign q_stat.full  = (cnt_r == 2'd2);
  assign q_stat.empty = (cnt_r == 2'd0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head_cmd     = entry_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (do_pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

@@ hdl/tbs_back.sv @@
module tbs_back import tbs_pkg::*; #(
  parameter int WAIT_DEPTH  = 64,
  parameter int READY_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOK_W-1:0] cfg_data,
  input  q_stat_t          q_stat,
  input  cmd_t             cmd,
  output logic             pop,
  output logic             out_valid,
  output logic [EV_W-1:0]  out_event_code,
  output logic [ID_W-1:0]  out_packet_id,
  output logic             out_moved_valid,
  output logic [ID_W-1:0]  out_moved_packet_id,
  output logic [TOK_W-1:0] out_token_level,
  output logic [CNT_W-1:0] out_first_queue_count,
  output logic [CNT_W-1:0] out_second_queue_count
);

  localparam int WA_W = $clog2(WAIT_DEPTH);
  localparam int WF_W = $clog2(WAIT_DEPTH + 1);
  localparam int RA_W = $clog2(READY_DEPTH);
  localparam int RF_W = $clog2(READY_DEPTH + 1);

  typedef enum logic {S_IDLE, S_EXEC} state_t;

  state_t           state_r;
  cmd_t             cmd_r;
  logic [TOK_W-1:0] tokens_r, tokens_nxt;
  logic [TOK_W-1:0] depth_r;
  logic [WA_W-1:0]  w_head_r, w_head_nxt, w_head_inc;
  logic [WA_W-1:0]  w_tail_r, w_tail_nxt, w_tail_inc;
  logic [WF_W-1:0]  w_fill_r, w_fill_nxt;
  logic [RA_W-1:0]  r_head_r, r_head_nxt, r_head_inc;
  logic [RA_W-1:0]  r_tail_r, r_tail_nxt, r_tail_inc;
  logic [RF_W-1:0]  r_fill_r, r_fill_nxt;

  logic [ID_W+TOK_W-1:0] wait_mem [WAIT_DEPTH];
  logic [ID_W-1:0]       ready_mem [READY_DEPTH];
  logic [ID_W+TOK_W-1:0] w_rd_r;
  logic [ID_W-1:0]       r_rd_r;
  logic [ID_W-1:0]       w_rd_id;
  logic [TOK_W-1:0]      w_rd_need;

  logic             w_we, r_we;
  logic [ID_W-1:0]  r_wdata;
  logic             w_full, w_empty, r_full;
  logic [TOK_W-1:0] tok_inc;
  logic [EV_W-1:0]  ev;
  logic [ID_W-1:0]  pid;
  logic             moved;
  logic [ID_W-1:0]  mid;

  assign cfg_ready = 1'b1;
  assign pop       = (state_r == S_IDLE) && !q_stat.empty;

  assign w_full  = (w_fill_r == WF_W'(WAIT_DEPTH));
  assign w_empty = (w_fill_r == '0);
  assign r_full  = (r_fill_r == RF_W'(READY_DEPTH));

  assign w_head_inc = (w_head_r == WA_W'(WAIT_DEPTH - 1)) ? '0 : w_head_r + 1'b1;
  assign w_tail_inc = (w_tail_r == WA_W'(WAIT_DEPTH - 1)) ? '0 : w_tail_r + 1'b1;
  assign r_head_inc = (r_head_r == RA_W'(READY_DEPTH - 1)) ? '0 : r_head_r + 1'b1;
  assign r_tail_inc = (r_tail_r == RA_W'(READY_DEPTH - 1)) ? '0 : r_tail_r + 1'b1;

  assign w_rd_id   = w_rd_r[ID_W+TOK_W-1:TOK_W];
  assign w_rd_need = w_rd_r[TOK_W-1:0];

  always_comb begin
    ev         = EV_QUEUED;
    pid        = '0;
    moved      = 1'b0;
    mid        = '0;
    tokens_nxt = tokens_r;
    w_head_nxt = w_head_r;
    w_tail_nxt = w_tail_r;
    w_fill_nxt = w_fill_r;
    r_head_nxt = r_head_r;
    r_tail_nxt = r_tail_r;
    r_fill_nxt = r_fill_r;
    w_we       = 1'b0;
    r_we       = 1'b0;
    r_wdata    = '0;
    tok_inc    = tokens_r;
    case (cmd_r.op)
      OP_ARRIVE: begin
        pid = cmd_r.pid;
        if (cmd_r.need > depth_r) begin
          ev = EV_TOO_BIG;
        end else if (w_full) begin
          ev = EV_Q1_FULL;
        end else begin
          w_we       = 1'b1;
          w_tail_nxt = w_tail_inc;
          // new head of an empty Q1 may move at once
          if (w_empty && !r_full && tokens_r >= cmd_r.need) begin
            moved      = 1'b1;
            mid        = cmd_r.pid;
            tokens_nxt = tokens_r - cmd_r.need;
            w_head_nxt = w_head_inc;
            r_we       = 1'b1;
            r_wdata    = cmd_r.pid;
            r_tail_nxt = r_tail_inc;
            r_fill_nxt = r_fill_r + 1'b1;
          end else begin
            w_fill_nxt = w_fill_r + 1'b1;
          end
        end
      end
      OP_TICK: begin
        if (tokens_r < depth_r) begin
          tok_inc = tokens_r + 1'b1;
          ev      = EV_TOK_ADD;
        end else begin
          ev      = EV_TOK_DROP;
        end
        tokens_nxt = tok_inc;
        if (!w_empty && !r_full && tok_inc >= w_rd_need) begin
          moved      = 1'b1;
          mid        = w_rd_id;
          tokens_nxt = tok_inc - w_rd_need;
          w_head_nxt = w_head_inc;
          w_fill_nxt = w_fill_r - 1'b1;
          r_we       = 1'b1;
          r_wdata    = w_rd_id;
          r_tail_nxt = r_tail_inc;
          r_fill_nxt = r_fill_r + 1'b1;
        end
      end
      default: begin
        if (r_fill_r != '0) begin
          ev         = EV_SERVED;
          pid        = r_rd_r;
          r_head_nxt = r_head_inc;
          r_fill_nxt = r_fill_r - 1'b1;
        end else begin
          ev = EV_Q2_EMPTY;
        end
      end
    endcase
  end

  // write only in execute; the head is read every cycle, and execute uses the copy read in issue
  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && w_we) begin
      wait_mem[w_tail_r] <= {cmd_r.pid, cmd_r.need};
    end
    w_rd_r <= wait_mem[w_head_r];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_EXEC && r_we) begin
      ready_mem[r_tail_r] <= r_wdata;
    end
    r_rd_r <= ready_mem[r_head_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      cmd_r           <= '0;
      tokens_r        <= '0;
      depth_r         <= DEPTH_RST;
      w_head_r        <= '0;
      w_tail_r        <= '0;
      w_fill_r        <= '0;
      r_head_r        <= '0;
      r_tail_r        <= '0;
      r_fill_r        <= '0;
      out_valid       <= 1'b0;
      out_event_code  <= EV_QUEUED;
      out_packet_id   <= '0;
      out_moved_valid <= 1'b0;
      out_moved_packet_id    <= '0;
      out_token_level        <= '0;
      out_first_queue_count  <= '0;
      out_second_queue_count <= '0;
    end else begin
      if (cfg_valid) begin
        depth_r <= cfg_data;
      end
      case (state_r)
        S_IDLE: begin
          out_valid <= 1'b0;
          if (pop) begin
            cmd_r   <= cmd;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          tokens_r        <= tokens_nxt;
          w_head_r        <= w_head_nxt;
          w_tail_r        <= w_tail_nxt;
          w_fill_r        <= w_fill_nxt;
          r_head_r        <= r_head_nxt;
          r_tail_r        <= r_tail_nxt;
          r_fill_r        <= r_fill_nxt;
          out_valid       <= 1'b1;
          out_event_code  <= ev;
          out_packet_id   <= pid;
          out_moved_valid <= moved;
          out_moved_packet_id    <= mid;
          out_token_level        <= tokens_nxt;
          out_first_queue_count  <= CNT_W'(w_fill_nxt);
          out_second_queue_count <= CNT_W'(r_fill_nxt);
          state_r         <= S_IDLE;
        end
        default: begin
          out_valid <= 1'b0;
          state_r   <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ hdl/token_bucket_shaper_top.sv @@
// Each accepted item passes the command queue, then the back end's issue and execute states, before its result strobe.
// The back end issues a queue-head memory read, then executes; it pops no new item until execute is done.
// busy rises when the 2-entry command queue between front and back end is full.
// Reset (rst_n low, synchronous): tokens 0, next id 1, depth 10, both packet queues empty.
// The receiver cannot stall: out_valid marks each result for exactly one cycle.
module token_bucket_shaper_top import tbs_pkg::*; #(
  parameter int WAIT_DEPTH  = 64,
  parameter int READY_DEPTH = 64
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  logic [REQ_W-1:0] in_req_type,
  input  logic [TOK_W-1:0] in_tokens_needed,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [TOK_W-1:0] cfg_data,
  output logic             out_valid,
  output logic [EV_W-1:0]  out_event_code,
  output logic [ID_W-1:0]  out_packet_id,
  output logic             out_moved_valid,
  output logic [ID_W-1:0]  out_moved_packet_id,
  output logic [TOK_W-1:0] out_token_level,
  output logic [CNT_W-1:0] out_first_queue_count,
  output logic [CNT_W-1:0] out_second_queue_count
);

  q_stat_t q_stat;
  logic    push;
  logic    pop;
  cmd_t    push_cmd;
  cmd_t    head_cmd;

  tbs_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .req_type      (in_req_type),
    .tokens_needed (in_tokens_needed),
    .q_stat        (q_stat),
    .busy          (busy),
    .push          (push),
    .cmd           (push_cmd)
  );

  tbs_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .head_cmd (head_cmd),
    .q_stat   (q_stat)
  );

  tbs_back #(
    .WAIT_DEPTH  (WAIT_DEPTH),
    .READY_DEPTH (READY_DEPTH)
  ) u_back (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_valid              (cfg_valid),
    .cfg_ready              (cfg_ready),
    .cfg_data               (cfg_data),
    .q_stat                 (q_stat),
    .cmd                    (head_cmd),
    .pop                    (pop),
    .out_valid              (out_valid),
    .out_event_code         (out_event_code),
    .out_packet_id          (out_packet_id),
    .out_moved_valid        (out_moved_valid),
    .out_moved_packet_id    (out_moved_packet_id),
    .out_token_level        (out_token_level),
    .out_first_queue_count  (out_first_queue_count),
    .out_second_queue_count (out_second_queue_count)
  );

endmodule

@@ hdl/tbs_checker.sv @@
`include "token_bucket_shaper_top_macros.svh"

module tbs_checker import tbs_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            busy,
  input logic            out_valid,
  input logic [EV_W-1:0] out_event_code,
  input logic [ID_W-1:0] out_packet_id,
  input logic            out_moved_valid,
  input logic [ID_W-1:0] out_moved_packet_id
);

  logic no_pid_ev;

  assign no_pid_ev = (out_event_code == EV_TOK_ADD) || (out_event_code == EV_TOK_DROP) ||
                     (out_event_code == EV_Q2_EMPTY);

  `TBS_ASSERT_NEXT(a_strobe_single, out_valid, !out_valid)
  `TBS_ASSERT_IMP(a_code_range, out_valid, out_event_code <= EV_Q2_EMPTY)
  `TBS_ASSERT_IMP(a_no_move_id, out_valid && !out_moved_valid, out_moved_packet_id == '0)
  `TBS_ASSERT_IMP(a_no_pkt_id, out_valid && no_pid_ev, out_packet_id == '0)
  `TBS_ASSERT_RST(a_reset_clear, !rst_n, !out_valid && !busy)

endmodule

bind token_bucket_shaper_top tbs_checker u_chk (.*);
